// ----- hw/rtl/rash_pkg.sv -----
// ----------------------------------------------------------------------------
// Range append sequence hash package
// Shared widths, codes, state type and the control bundle of the hash ring.
// ----------------------------------------------------------------------------
package rash_pkg;

    // Number of hash positions kept in the ring of cells.
    localparam int POSITIONS = 256;

    localparam int HASH_W  = 64;
    localparam int SYM_W   = 32;
    localparam int FIELD_W = 8;
    localparam int CFG_W   = 9;
    localparam int POS_W   = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int COUNT_W = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;

    localparam logic [POS_W-1:0] LAST_STEP = POS_W'(POSITIONS - 1);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    // Item modes.
    localparam logic MODE_APPEND  = 1'b0;
    localparam logic MODE_COMPARE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_DONE
    } state_t;

    // Everything the head unit needs for one step of a pass.
    typedef struct packed {
        logic                 shift_en;
        logic                 mode;
        logic [POS_W-1:0]     step;
        logic [COUNT_W-1:0]   count;
        logic [FIELD_W-1:0]   range_first;
        logic [FIELD_W-1:0]   range_last;
        logic [SYM_W-1:0]     symbol;
        logic [FIELD_W-1:0]   pos_a;
        logic [FIELD_W-1:0]   pos_b;
        logic                 pend_valid;
        logic [FIELD_W-1:0]   pend_a;
        logic [FIELD_W-1:0]   pend_b;
    } head_ctrl_t;

endpackage

// ----- hw/rtl/range_append_sequence_hash.sv -----
// ----------------------------------------------------------------------------
// Range append sequence hash
// Keeps one 64-bit polynomial hash per position in a ring of cells.
// ----------------------------------------------------------------------------
// Usage: an input word (in_valid/in_stall) either appends a sign-extended
// symbol to a range of positions (hash = hash * 257 + symbol) or compares two
// positions. A compare returns one output word (out_valid/out_stall) whose
// field same is 1 when both positions are in use and their hashes matched;
// those two hashes are then zero. An append returns no word. The config
// channel (cfg_valid/cfg_ready) writes positions_in_use and is ready only
// while no item is in progress. The hashes sit in a ring of POSITIONS cells
// that rotates by one cell per cycle while an item is in progress; a single
// head unit sees every position once per rotation. Each item takes one full
// rotation. After a compare's rotation the block enters its done state,
// where the result is loaded into the output register; the clearing of a
// matching pair is carried into the next item's rotation, ahead of that
// item's own work. A new item is accepted only when no rotation is running
// and no compare waits in its done state. A result that the receiver stalls
// stays on the output; the next item can still be taken, but a later
// compare waits at its end until the old result has been taken.
// Reset zeroes every hash and sets positions_in_use to 256.
// ----------------------------------------------------------------------------
module range_append_sequence_hash (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [rash_pkg::FIELD_W-1:0]        range_first,
    input  logic [rash_pkg::FIELD_W-1:0]        range_last,
    input  logic signed [rash_pkg::SYM_W-1:0]   symbol,
    input  logic [rash_pkg::FIELD_W-1:0]        pos_a,
    input  logic [rash_pkg::FIELD_W-1:0]        pos_b,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                same,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rash_pkg::CFG_W-1:0]          positions_in_use
);

    rash_pkg::state_t state_reg;
    rash_pkg::state_t state_next;

    // Item held for the length of its rotation.
    logic                           mode_reg;
    logic [rash_pkg::FIELD_W-1:0]   first_reg;
    logic [rash_pkg::FIELD_W-1:0]   last_reg;
    logic [rash_pkg::SYM_W-1:0]     symbol_reg;
    logic [rash_pkg::FIELD_W-1:0]   pos_a_reg;
    logic [rash_pkg::FIELD_W-1:0]   pos_b_reg;

    logic [rash_pkg::POS_W-1:0]     step_reg;
    logic [rash_pkg::POS_W-1:0]     step_next;
    logic [rash_pkg::CFG_W-1:0]     cfg_reg;
    logic [rash_pkg::COUNT_W-1:0]   count;

    // Clear pending from the last matching compare.
    logic                           pend_valid_reg;
    logic                           pend_valid_next;
    logic [rash_pkg::FIELD_W-1:0]   pend_a_reg;
    logic [rash_pkg::FIELD_W-1:0]   pend_b_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           same_reg;

    logic                           accept;
    logic                           shift_en;
    logic                           last_step;
    logic                           result_load;
    logic                           match;

    rash_pkg::head_ctrl_t           ctrl;
    logic [rash_pkg::HASH_W-1:0]    ring [rash_pkg::POSITIONS];
    logic [rash_pkg::HASH_W-1:0]    head_out;
    logic [rash_pkg::HASH_W-1:0]    hash_a;
    logic [rash_pkg::HASH_W-1:0]    hash_b;

    // Active count: a register value above the ring size acts as the size.
    assign count = (rash_pkg::COUNT_W'(cfg_reg) > rash_pkg::COUNT_W'(rash_pkg::POSITIONS)) ?
                   rash_pkg::COUNT_W'(rash_pkg::POSITIONS) : rash_pkg::COUNT_W'(cfg_reg);

    assign last_step = (step_reg == rash_pkg::LAST_STEP);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rash_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rash_pkg::ST_PASS;
                end
            end
            rash_pkg::ST_PASS:
            begin
                if (last_step)
                begin
                    state_next = (mode_reg == rash_pkg::MODE_COMPARE) ?
                                 rash_pkg::ST_DONE : rash_pkg::ST_IDLE;
                end
            end
            rash_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = rash_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rash_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_stall    = 1'b1;
        cfg_ready   = 1'b0;
        shift_en    = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            rash_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
            end
            rash_pkg::ST_PASS:
            begin
                shift_en = 1'b1;
            end
            rash_pkg::ST_DONE:
            begin
                result_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    // Both positions must be in use and their hashes equal.
    assign match = (rash_pkg::COUNT_W'(pos_a_reg) < count) &&
                   (rash_pkg::COUNT_W'(pos_b_reg) < count) &&
                   (hash_a == hash_b);

    always_comb
    begin
        step_next = step_reg;
        if (accept)
        begin
            step_next = '0;
        end
        else if (shift_en)
        begin
            step_next = step_reg + 1'b1;
        end

        pend_valid_next = pend_valid_reg;
        if (result_load)
        begin
            pend_valid_next = match;
        end
        else if (shift_en && last_step)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rash_pkg::ST_IDLE;
            step_reg       <= '0;
            cfg_reg        <= rash_pkg::CFG_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= positions_in_use;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            first_reg  <= range_first;
            last_reg   <= range_last;
            symbol_reg <= symbol;
            pos_a_reg  <= pos_a;
            pos_b_reg  <= pos_b;
        end
        if (result_load)
        begin
            same_reg   <= match;
            pend_a_reg <= pos_a_reg;
            pend_b_reg <= pos_b_reg;
        end
    end

    always_comb
    begin
        ctrl.shift_en    = shift_en;
        ctrl.mode        = mode_reg;
        ctrl.step        = step_reg;
        ctrl.count       = count;
        ctrl.range_first = first_reg;
        ctrl.range_last  = last_reg;
        ctrl.symbol      = symbol_reg;
        ctrl.pos_a       = pos_a_reg;
        ctrl.pos_b       = pos_b_reg;
        ctrl.pend_valid  = pend_valid_reg;
        ctrl.pend_a      = pend_a_reg;
        ctrl.pend_b      = pend_b_reg;
    end

    // Cell 0 always holds the position being worked on; the head writes the
    // updated hash into the far end of the ring.
    rash_head u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .hash_in  (ring[0]),
        .hash_out (head_out),
        .hash_a   (hash_a),
        .hash_b   (hash_b)
    );

    for (genvar gi = 0; gi < rash_pkg::POSITIONS; gi++)
    begin : g_cell
        if (gi == rash_pkg::POSITIONS - 1)
        begin : g_tail
            rash_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .hash_in  (head_out),
                .hash_out (ring[gi])
            );
        end
        else
        begin : g_body
            rash_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .hash_in  (ring[gi+1]),
                .hash_out (ring[gi])
            );
        end
    end

    assign out_valid = out_valid_reg;
    assign same      = same_reg;

    // An accepted item starts a rotation at the first position.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == rash_pkg::ST_PASS) && (step_reg == '0))
        else $error("accepted item did not start a rotation");

    // A rotation never runs past its last position.
    a_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rash_pkg::ST_PASS) && last_step |=> (state_reg != rash_pkg::ST_PASS))
        else $error("rotation ran past the last position");

    // A new result only appears after a compare's rotation.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rash_pkg::ST_DONE))
        else $error("result appeared without a compare");

    // The ring never rotates while the config port is open.
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !shift_en)
        else $error("config port open during a rotation");

endmodule

// ----- hw/rtl/rash_cell.sv -----
// ----------------------------------------------------------------------------
// Hash ring cell
// Holds one 64-bit hash and takes its neighbor's hash on every shift.
// ----------------------------------------------------------------------------
module rash_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  logic [rash_pkg::HASH_W-1:0] hash_in,
    output logic [rash_pkg::HASH_W-1:0] hash_out
);

    logic [rash_pkg::HASH_W-1:0] hash_reg;
    logic [rash_pkg::HASH_W-1:0] hash_next;

    always_comb
    begin
        hash_next = shift_en ? hash_in : hash_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash_out = hash_reg;

endmodule

// ----- hw/rtl/rash_head.sv -----
// ----------------------------------------------------------------------------
// Hash ring head unit
// Updates the hash that passes the ring's head and captures compared hashes.
// ----------------------------------------------------------------------------
module rash_head (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rash_pkg::head_ctrl_t        ctrl,
    input  logic [rash_pkg::HASH_W-1:0] hash_in,
    output logic [rash_pkg::HASH_W-1:0] hash_out,
    output logic [rash_pkg::HASH_W-1:0] hash_a,
    output logic [rash_pkg::HASH_W-1:0] hash_b
);

    logic [rash_pkg::COUNT_W-1:0] step_ext;
    logic                         clear_hit;
    logic                         in_range;
    logic [rash_pkg::HASH_W-1:0]  base_val;
    logic [rash_pkg::HASH_W-1:0]  sym_ext;
    logic                         hit_a;
    logic                         hit_b;
    logic [rash_pkg::HASH_W-1:0]  hash_a_reg;
    logic [rash_pkg::HASH_W-1:0]  hash_a_next;
    logic [rash_pkg::HASH_W-1:0]  hash_b_reg;
    logic [rash_pkg::HASH_W-1:0]  hash_b_next;

    always_comb
    begin
        step_ext = rash_pkg::COUNT_W'(ctrl.step);
        // A clear decided by the last compare is applied on this pass.
        clear_hit = ctrl.pend_valid &&
                    ((step_ext == rash_pkg::COUNT_W'(ctrl.pend_a)) ||
                     (step_ext == rash_pkg::COUNT_W'(ctrl.pend_b)));
        base_val = clear_hit ? '0 : hash_in;
        sym_ext  = {{(rash_pkg::HASH_W - rash_pkg::SYM_W){ctrl.symbol[rash_pkg::SYM_W-1]}},
                    ctrl.symbol};
        in_range = (ctrl.mode == rash_pkg::MODE_APPEND) &&
                   (step_ext >= rash_pkg::COUNT_W'(ctrl.range_first)) &&
                   (step_ext <= rash_pkg::COUNT_W'(ctrl.range_last)) &&
                   (step_ext < ctrl.count);
        // Multiplying by 257 is a shift by eight plus the value itself.
        hash_out = in_range ? ((base_val << 8) + base_val + sym_ext) : base_val;

        hit_a = ctrl.shift_en && (ctrl.mode == rash_pkg::MODE_COMPARE) &&
                (step_ext == rash_pkg::COUNT_W'(ctrl.pos_a));
        hit_b = ctrl.shift_en && (ctrl.mode == rash_pkg::MODE_COMPARE) &&
                (step_ext == rash_pkg::COUNT_W'(ctrl.pos_b));
        hash_a_next = hit_a ? base_val : hash_a_reg;
        hash_b_next = hit_b ? base_val : hash_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_a_reg <= '0;
            hash_b_reg <= '0;
        end
        else
        begin
            hash_a_reg <= hash_a_next;
            hash_b_reg <= hash_b_next;
        end
    end

    assign hash_a = hash_a_reg;
    assign hash_b = hash_b_reg;

endmodule

// ----- tb/tb_range_append_sequence_hash.sv -----
// ----------------------------------------------------------------------------
// Range append sequence hash testbench
// Drives append and compare words into the hash ring and checks every compare
// result against a bit-accurate mirror of the per-position hashes and of the
// positions_in_use register.
// ----------------------------------------------------------------------------
module tb_range_append_sequence_hash;

    // Multiplier of the polynomial hash.
    localparam logic [rash_pkg::HASH_W-1:0] HASH_BASE = 64'd257;

    // One rotation of the ring plus margin. This is used before a register
    // write, because an append word returns nothing and may still be rotating
    // when the last compare result has come back. It is also used at the end.
    localparam int SETTLE_CYCLES = rash_pkg::POSITIONS + 40;

    // The slowest correct run is about 1750 words, plus register writes and the
    // long receiver hold-off. The limit is several times that.
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int HOLD_CYCLES      = 3000;
    localparam int RANDOM_PHASES    = 10;
    localparam int RANDOM_PER_PHASE = 171;
    localparam int REPORT_LIMIT     = 10;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               mode = rash_pkg::MODE_APPEND;
    logic [rash_pkg::FIELD_W-1:0]       range_first = '0;
    logic [rash_pkg::FIELD_W-1:0]       range_last = '0;
    logic signed [rash_pkg::SYM_W-1:0]  symbol = '0;
    logic [rash_pkg::FIELD_W-1:0]       pos_a = '0;
    logic [rash_pkg::FIELD_W-1:0]       pos_b = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               same;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [rash_pkg::CFG_W-1:0]         positions_in_use = rash_pkg::CFG_RESET;

    // Mirror of the block's state and of its one register.
    logic [rash_pkg::HASH_W-1:0]        hash_mirror [rash_pkg::POSITIONS];
    logic [rash_pkg::CFG_W-1:0]         count_mirror;

    // Compare results still owed by the block, oldest first.
    logic                               same_expected [$];
    int                                 mismatch_count = 0;

    // When steady is set, neither side inserts idle cycles. The receiver
    // hold-off runs in its own process and is started by hold_request.
    logic                               steady = 1'b0;
    logic                               hold_request = 1'b0;
    logic                               rx_hold = 1'b0;

    range_append_sequence_hash dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .range_first      (range_first),
        .range_last       (range_last),
        .symbol           (symbol),
        .pos_a            (pos_a),
        .pos_b            (pos_b),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .same             (same),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .positions_in_use (positions_in_use)
    );

    always #10 clk = ~clk;

    // A count above the store size behaves as the full store.
    function automatic int active_positions();
        return (count_mirror > rash_pkg::POSITIONS) ? rash_pkg::POSITIONS :
                                                      int'(count_mirror);
    endfunction

    // Applies one accepted word to the mirror. An append folds the sign
    // extended symbol into every in-use position of the inclusive range; a
    // compare queues its result and clears both positions on a match.
    task automatic update_hash_mirror(input logic m,
                                      input logic [rash_pkg::FIELD_W-1:0] first,
                                      input logic [rash_pkg::FIELD_W-1:0] last,
                                      input logic [rash_pkg::SYM_W-1:0] sym,
                                      input logic [rash_pkg::FIELD_W-1:0] a,
                                      input logic [rash_pkg::FIELD_W-1:0] b);
        int n;
        logic [rash_pkg::HASH_W-1:0] ext;
        n = active_positions();
        ext = {{(rash_pkg::HASH_W-rash_pkg::SYM_W){sym[rash_pkg::SYM_W-1]}}, sym};
        if (m == rash_pkg::MODE_APPEND)
        begin
            for (int p = int'(first); p <= int'(last) && p < n; p++)
                hash_mirror[p] = hash_mirror[p] * HASH_BASE + ext;
        end
        else if (int'(a) < n && int'(b) < n && hash_mirror[a] == hash_mirror[b])
        begin
            hash_mirror[a] = '0;
            hash_mirror[b] = '0;
            same_expected.push_back(1'b1);
        end
        else
        begin
            same_expected.push_back(1'b0);
        end
    endtask

    // Offers one word after a random idle gap and holds it until the block
    // takes it. Valid is left high on return, so a following word with no gap
    // keeps valid up without a lower-and-raise in the same step.
    task automatic send_word(input logic m, input logic [rash_pkg::FIELD_W-1:0] first,
                             input logic [rash_pkg::FIELD_W-1:0] last,
                             input logic [rash_pkg::SYM_W-1:0] sym,
                             input logic [rash_pkg::FIELD_W-1:0] a,
                             input logic [rash_pkg::FIELD_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        range_first <= first;
        range_last  <= last;
        symbol      <= sym;
        pos_a       <= a;
        pos_b       <= b;
        do
            @(posedge clk);
        while (in_stall);
        update_hash_mirror(m, first, last, sym, a, b);
    endtask

    // Writes positions_in_use once the block is idle: every owed result has
    // come back and a full rotation has passed for any trailing append.
    task automatic write_count(input logic [rash_pkg::CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (same_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid        <= 1'b1;
        positions_in_use <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        count_mirror = value;
    endtask

    // Corners of the fields with the full store in use: widest and narrowest
    // ranges, extreme symbols, an empty range, a position compared with
    // itself, equal and unequal pairs at both ends of the store.
    task automatic test_directed_extremes();
        write_count(rash_pkg::CFG_W'(rash_pkg::POSITIONS));
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd0, 8'd255);
        send_word(rash_pkg::MODE_APPEND, 8'd0, 8'd255, 32'h7fff_ffff, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_APPEND, 8'd0, 8'd255, 32'h8000_0000, 8'd255, 8'd255);
        send_word(rash_pkg::MODE_APPEND, 8'd255, 8'd255, 32'hffff_ffff, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_APPEND, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_APPEND, 8'd200, 8'd100, 32'd5, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd1, 8'd2);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd1, 8'd3);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd255, 8'd254);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd2, 8'd1);
        send_word(rash_pkg::MODE_APPEND, 8'd3, 8'd254, 32'h5555_aaaa, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_APPEND, 8'd0, 8'd255, 32'haaaa_5555, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd128, 8'd129);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd255, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd254, 8'd254);
    endtask

    // Register settings at and beyond the legal range: a single position,
    // no position at all, and counts above the store size.
    task automatic test_count_settings();
        write_count(rash_pkg::CFG_W'(1));
        send_word(rash_pkg::MODE_APPEND, 8'd0, 8'd255, 32'd7, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd0, 8'd1);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd255, 8'd0);
        write_count(rash_pkg::CFG_W'(0));
        send_word(rash_pkg::MODE_APPEND, 8'd0, 8'd255, 32'd9, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0);
        write_count(9'h1ff);
        send_word(rash_pkg::MODE_APPEND, 8'd250, 8'd255, 32'hffff_fffe, 8'd0, 8'd0);
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd254, 8'd255);
        write_count(rash_pkg::CFG_W'(rash_pkg::POSITIONS + 1));
        send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0, 8'd255, 8'd255);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering compare words, so the held result blocks a later compare and
    // the block has to stall its input.
    task automatic test_backpressure();
        write_count(rash_pkg::CFG_W'(rash_pkg::POSITIONS));
        steady       = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 4 == 3)
                send_word(rash_pkg::MODE_APPEND,
                          rash_pkg::FIELD_W'($urandom_range(0, 31)),
                          rash_pkg::FIELD_W'($urandom_range(16, 63)), $urandom,
                          8'd0, 8'd0);
            else
                send_word(rash_pkg::MODE_COMPARE, 8'd0, 8'd0, 32'd0,
                          rash_pkg::FIELD_W'($urandom_range(0, 63)),
                          rash_pkg::FIELD_W'($urandom_range(0, 63)));
        end
        steady = 1'b0;
    endtask

    // Random traffic in phases, each with its own register setting. Most
    // appends use short ranges near the in-use positions and most compares
    // pick nearby positions, so equal hashes and clears come up often; the
    // rest are empty ranges, fully random fields and out-of-count compares.
    task automatic test_random_traffic();
        int active;
        int span;
        int pick;
        int lo;
        int hi;
        logic [rash_pkg::SYM_W-1:0] sym;
        logic [rash_pkg::FIELD_W-1:0] a;
        logic [rash_pkg::FIELD_W-1:0] b;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                write_count(rash_pkg::CFG_W'($urandom_range(1, 32)));
            else if (pick < 70)
                write_count(rash_pkg::CFG_W'(rash_pkg::POSITIONS));
            else if (pick < 85)
                write_count(rash_pkg::CFG_W'($urandom_range(33, 255)));
            else if (pick < 90)
                write_count(rash_pkg::CFG_W'(1));
            else if (pick < 95)
                write_count(rash_pkg::CFG_W'(0));
            else
                write_count(rash_pkg::CFG_W'($urandom_range(257, 511)));
            steady = (phase % 4 == 3);
            active = active_positions();
            span   = (active == 0) ? 1 : active;
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       sym = 32'd0;
                    1:       sym = 32'hffff_ffff;
                    2:       sym = ($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
                    default: sym = $urandom;
                endcase
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 0)
                begin
                    if (pick < 70)
                    begin
                        lo = $urandom_range(0, span - 1);
                        hi = lo + $urandom_range(0, (pick < 35) ? 3 : span - 1);
                        if (hi > 255)
                            hi = 255;
                    end
                    else if (pick < 80)
                    begin
                        // Empty range: last below first.
                        hi = $urandom_range(0, 254);
                        lo = $urandom_range(hi + 1, 255);
                    end
                    else
                    begin
                        lo = $urandom_range(0, 255);
                        hi = $urandom_range(0, 255);
                    end
                    send_word(rash_pkg::MODE_APPEND, rash_pkg::FIELD_W'(lo),
                              rash_pkg::FIELD_W'(hi), sym,
                              rash_pkg::FIELD_W'($urandom), rash_pkg::FIELD_W'($urandom));
                end
                else
                begin
                    if (pick < 60)
                    begin
                        lo = $urandom_range(0, span - 1);
                        hi = lo + $urandom_range(0, 3);
                        if (hi > span - 1)
                            hi = span - 1;
                    end
                    else if (pick < 75)
                    begin
                        lo = $urandom_range(0, span - 1);
                        hi = lo;
                    end
                    else if (pick < 90)
                    begin
                        lo = $urandom_range(0, 255);
                        hi = $urandom_range(0, 255);
                    end
                    else
                    begin
                        // One side at or past the count, or 255 when all in use.
                        lo = $urandom_range((active > 255) ? 255 : active, 255);
                        hi = $urandom_range(0, span - 1);
                    end
                    a = rash_pkg::FIELD_W'(lo);
                    b = rash_pkg::FIELD_W'(hi);
                    if ($urandom_range(0, 1) == 0)
                        send_word(rash_pkg::MODE_COMPARE, rash_pkg::FIELD_W'($urandom),
                                  rash_pkg::FIELD_W'($urandom), sym, a, b);
                    else
                        send_word(rash_pkg::MODE_COMPARE, rash_pkg::FIELD_W'($urandom),
                                  rash_pkg::FIELD_W'($urandom), sym, b, a);
                end
            end
        end
        steady = 1'b0;
    endtask

    // Receiver. Before each result it stalls for a random number of cycles
    // counted while a word is waiting, and it stays stalled for the whole of
    // a requested hold-off. Every word taken is checked against the oldest
    // owed result.
    initial
    begin : result_checker
        int stall_left;
        logic want;
        stall_left = $urandom_range(0, 15);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (same_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result word: same=%0b", same);
                end
                else
                begin
                    want = same_expected.pop_front();
                    if (same !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("same mismatch: expected %0b, got %0b", want, same);
                    end
                end
                stall_left = steady ? 0 : $urandom_range(0, 15);
            end
            else if (out_valid === 1'b1 && stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= rx_hold || (stall_left > 0);
        end
    end

    // Long receiver hold-off, counted in cycles here.
    always
    begin
        wait (hold_request);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold      <= 1'b0;
        hold_request = 1'b0;
    end

    // Watchdog: ends the run if it has not finished by the limit.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_range_append_sequence_hash failed");
        $finish;
    end

    initial
    begin : main_sequence
        // The mirror starts in the reset state of the block.
        for (int p = 0; p < rash_pkg::POSITIONS; p++)
            hash_mirror[p] = '0;
        count_mirror = rash_pkg::CFG_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_count_settings();
        test_backpressure();
        test_random_traffic();

        // Drain: wait for every owed result, then one more rotation so a
        // stray late word would still be seen by the checker.
        in_valid <= 1'b0;
        while (same_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_range_append_sequence_hash passed");
        else
            $display("tb_range_append_sequence_hash failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rash_pkg.sv
hw/rtl/rash_cell.sv
hw/rtl/rash_head.sv
hw/rtl/range_append_sequence_hash.sv
tb/tb_range_append_sequence_hash.sv
